// ----- rtl/ckp_pkg.sv -----
// Shared types, codes and decode tables for the keyer host command parser.
package ckp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ADMIN  = 2'd1,
        PH_PARAM1 = 2'd2,
        PH_PARAM2 = 2'd3
    } phase_t;

    // Admin subcommands.
    localparam logic [7:0] SUB_RESET = 8'h01;
    localparam logic [7:0] SUB_OPEN  = 8'h02;
    localparam logic [7:0] SUB_CLOSE = 8'h03;
    localparam logic [7:0] SUB_ECHO  = 8'h04;

    // Command bytes with special handling.
    localparam logic [4:0] CMD_ADMIN = 5'h00;
    localparam logic [4:0] CMD_PTT   = 5'h04;
    localparam logic [4:0] CMD_CLEAR = 5'h0A;

    // Byte class limits.
    localparam logic [7:0] CMD_MAX  = 8'h1F;
    localparam logic [7:0] TEXT_MAX = 8'h7F;

    // Event codes.
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_OPEN     = 4'd1;
    localparam logic [3:0] EV_CLOSE    = 4'd2;
    localparam logic [3:0] EV_CLEAR    = 4'd3;
    localparam logic [3:0] EV_SPEED    = 4'd4;
    localparam logic [3:0] EV_SIDETONE = 4'd5;
    localparam logic [3:0] EV_WEIGHT   = 4'd6;
    localparam logic [3:0] EV_PINS     = 4'd7;
    localparam logic [3:0] EV_MODE     = 4'd8;
    localparam logic [3:0] EV_KEY      = 4'd9;
    localparam logic [3:0] EV_PAUSE    = 4'd10;
    localparam logic [3:0] EV_PTT      = 4'd11;
    localparam logic [3:0] EV_TEXT     = 4'd12;

    localparam logic [7:0] VERSION_RESET = 8'd31;

    typedef struct packed {
        phase_t     phase;
        logic [4:0] pending_command;
        logic [7:0] held_parameter;
        logic       session_active;
    } parser_state_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_valid;
        logic [7:0] arg_second;
        logic [7:0] arg_first;
        logic [3:0] event_code;
    } result_t;

    // Number of parameter bytes that follow a command byte.
    function automatic logic [1:0] param_bytes(input logic [4:0] cmd);
        logic [1:0] n;
        unique case (cmd)
            5'h01, 5'h02, 5'h03, 5'h05, 5'h06,
            5'h09, 5'h0B, 5'h0C, 5'h0D, 5'h0E: n = 2'd1;
            CMD_PTT:                           n = 2'd2;
            default:                           n = 2'd0;
        endcase
        return n;
    endfunction

    // Event raised by a one-parameter command once its parameter arrives.
    function automatic logic [3:0] single_event(input logic [4:0] cmd);
        logic [3:0] ev;
        unique case (cmd)
            5'h02:   ev = EV_SPEED;
            5'h01:   ev = EV_SIDETONE;
            5'h03:   ev = EV_WEIGHT;
            5'h09:   ev = EV_PINS;
            5'h0E:   ev = EV_MODE;
            5'h0B:   ev = EV_KEY;
            5'h06:   ev = EV_PAUSE;
            default: ev = EV_NONE;
        endcase
        return ev;
    endfunction

endpackage

// ----- rtl/ckp_decode.sv -----
// Byte decoder: next parser state and the result for one host byte.
module ckp_decode
(
    input  ckp_pkg::parser_state_t state,
    input  logic [7:0]             host_byte,
    input  logic [7:0]             version_byte,
    output ckp_pkg::parser_state_t state_next,
    output ckp_pkg::result_t       result
);

    logic [3:0] single_ev;

    assign single_ev = ckp_pkg::single_event(state.pending_command);

    always_comb
    begin
        state_next = state;
        result     = '0;

        unique case (state.phase)
            ckp_pkg::PH_IDLE:
            begin
                if (host_byte <= ckp_pkg::CMD_MAX)
                begin
                    if (host_byte[4:0] == ckp_pkg::CMD_ADMIN)
                    begin
                        state_next.phase = ckp_pkg::PH_ADMIN;
                    end
                    else if (ckp_pkg::param_bytes(host_byte[4:0]) != 2'd0)
                    begin
                        state_next.pending_command = host_byte[4:0];
                        state_next.phase           = ckp_pkg::PH_PARAM1;
                    end
                    else if (state.session_active &&
                             host_byte[4:0] == ckp_pkg::CMD_CLEAR)
                    begin
                        result.event_code = ckp_pkg::EV_CLEAR;
                    end
                end
                else if (host_byte <= ckp_pkg::TEXT_MAX)
                begin
                    if (state.session_active)
                    begin
                        result.event_code = ckp_pkg::EV_TEXT;
                        result.arg_first  = host_byte;
                    end
                end
            end

            ckp_pkg::PH_ADMIN:
            begin
                state_next.phase = ckp_pkg::PH_IDLE;
                if (host_byte == ckp_pkg::SUB_OPEN)
                begin
                    state_next.session_active = 1'b1;
                    result.event_code         = ckp_pkg::EV_OPEN;
                    result.reply_valid        = 1'b1;
                    result.reply_byte         = version_byte;
                end
                else if (host_byte == ckp_pkg::SUB_CLOSE)
                begin
                    state_next.session_active = 1'b0;
                    result.event_code         = ckp_pkg::EV_CLOSE;
                end
                else if (host_byte == ckp_pkg::SUB_RESET)
                begin
                    state_next.session_active = 1'b0;
                end
                else if (host_byte == ckp_pkg::SUB_ECHO)
                begin
                    // The echo marker reuses the parameter slot.
                    state_next.pending_command = ckp_pkg::CMD_ADMIN;
                    state_next.held_parameter  = ckp_pkg::SUB_ECHO;
                    state_next.phase           = ckp_pkg::PH_PARAM1;
                end
            end

            ckp_pkg::PH_PARAM1:
            begin
                state_next.phase = ckp_pkg::PH_IDLE;
                if (state.pending_command == ckp_pkg::CMD_ADMIN &&
                    state.held_parameter == ckp_pkg::SUB_ECHO)
                begin
                    result.reply_valid = 1'b1;
                    result.reply_byte  = host_byte;
                end
                else if (ckp_pkg::param_bytes(state.pending_command) == 2'd2)
                begin
                    if (state.session_active)
                    begin
                        state_next.held_parameter = host_byte;
                    end
                    state_next.phase = ckp_pkg::PH_PARAM2;
                end
                else if (state.session_active)
                begin
                    result.event_code = single_ev;
                    if (single_ev == ckp_pkg::EV_KEY || single_ev == ckp_pkg::EV_PAUSE)
                    begin
                        result.arg_first = {7'd0, host_byte != 8'd0};
                    end
                    else if (single_ev != ckp_pkg::EV_NONE)
                    begin
                        result.arg_first = host_byte;
                    end
                end
            end

            ckp_pkg::PH_PARAM2:
            begin
                state_next.phase = ckp_pkg::PH_IDLE;
                if (state.session_active && state.pending_command == ckp_pkg::CMD_PTT)
                begin
                    result.event_code = ckp_pkg::EV_PTT;
                    result.arg_first  = state.held_parameter;
                    result.arg_second = host_byte;
                end
            end

            default:
            begin
                state_next.phase = ckp_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cw_keyer_host_command_parser.sv -----
// Top level of the keyer host command parser: input stage, parser state and result stage.
//
// The parser takes one host byte per clock unless stalled and gives exactly one result per
// byte, in order. A byte is captured in the input register, decoded against the parse state
// in a single short pass, and the result moves to the output register once that one is free.
// Sustained throughput is one byte per cycle while results are taken, set by the single
// decode stage between the two registers; the input side keeps accepting while a finished
// result waits, and stalls only when both registers are full and the waiting result is not
// being taken. The version byte is written through the cfg port, which is always ready, and
// must only be written while the parser holds no byte in flight.
module cw_keyer_host_command_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] host_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] event_code, [11:4] arg_first,
                                   // [19:12] arg_second, [20] reply_valid,
                                   // [28:21] reply_byte, [31:29] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    ckp_pkg::result_t       out_result_reg;
    ckp_pkg::parser_state_t state_reg;
    ckp_pkg::parser_state_t state_next;
    ckp_pkg::result_t       result_next;
    logic [7:0]             version_reg;
    logic                   advance;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'd0, out_result_reg};

    ckp_decode u_decode
    (
        .state        (state_reg),
        .host_byte    (in_byte_reg),
        .version_byte (version_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: ckp_pkg::PH_IDLE, pending_command: 5'd0,
                               held_parameter: 8'd0, session_active: 1'b0};
            version_reg   <= ckp_pkg::VERSION_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
            if (cfg_valid)
            begin
                version_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/ckp_checker.sv -----
// Port-level assertions for the keyer host command parser, bound to the top level.
module ckp_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side never stalls while the output side is taking results.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    // A reply byte goes back only on session open or on echo.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |->
            (m_tdata[3:0] == ckp_pkg::EV_OPEN || m_tdata[3:0] == ckp_pkg::EV_NONE))
        else $error("reply with unexpected event");

    // Only ptt timing carries a second argument; padding stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] != ckp_pkg::EV_PTT |->
            m_tdata[19:12] == 8'd0 && m_tdata[31:29] == 3'd0)
        else $error("stray second argument or padding");

    // With the output empty and no byte accepted while the input register drains, no result appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !(s_tvalid && s_tready) ##1 !m_tvalid && !(s_tvalid && s_tready)
            |=> !m_tvalid)
        else $error("result without an accepted byte");

endmodule

bind cw_keyer_host_command_parser ckp_port_checker u_ckp_checker (.*);

// ----- sim/ckp_checker.sv -----
// Stimulus command codes and the checker that predicts and compares the parser's results.
package ckp_tb_pkg;

    // One-parameter host commands.
    localparam logic [7:0] CMD_SIDETONE   = 8'h01;
    localparam logic [7:0] CMD_SPEED      = 8'h02;
    localparam logic [7:0] CMD_WEIGHT     = 8'h03;
    localparam logic [7:0] CMD_SPEED_POT  = 8'h05;
    localparam logic [7:0] CMD_PAUSE      = 8'h06;
    localparam logic [7:0] CMD_PINS       = 8'h09;
    localparam logic [7:0] CMD_KEY        = 8'h0B;
    localparam logic [7:0] CMD_HSCW       = 8'h0C;
    localparam logic [7:0] CMD_FARNSWORTH = 8'h0D;
    localparam logic [7:0] CMD_MODE       = 8'h0E;

    // Parameterless host commands.
    localparam logic [7:0] CMD_GET_POT    = 8'h07;
    localparam logic [7:0] CMD_BACKSPACE  = 8'h08;
    localparam logic [7:0] CMD_NOARG_LO   = 8'h0F;
    localparam logic [7:0] CMD_NOARG_HI   = 8'h1F;

    localparam int ONE_ARG_COUNT = 10;

    function automatic logic [7:0] one_arg_command(input int unsigned i);
        logic [7:0] c;
        case (i)
            0:       c = CMD_SIDETONE;
            1:       c = CMD_SPEED;
            2:       c = CMD_WEIGHT;
            3:       c = CMD_SPEED_POT;
            4:       c = CMD_PAUSE;
            5:       c = CMD_PINS;
            6:       c = CMD_KEY;
            7:       c = CMD_HSCW;
            8:       c = CMD_FARNSWORTH;
            default: c = CMD_MODE;
        endcase
        return c;
    endfunction

endpackage

module ckp_checker
    import ckp_pkg::*;
    import ckp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] host_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [3:0] event_code, [11:4] arg_first,
                                   // [19:12] arg_second, [20] reply_valid,
                                   // [28:21] reply_byte, [31:29] zero
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding,
    output logic [15:0] events_seen,
    output int          replies_seen
);

    phase_t     phase;
    logic [4:0] cmd_held;
    logic [7:0] first_param;
    bit         link_open;
    logic [7:0] version_reg;
    result_t    expected_q[$];

    function automatic int unsigned arg_bytes(input logic [4:0] c);
        case ({3'b000, c})
            CMD_SIDETONE, CMD_SPEED, CMD_WEIGHT, CMD_SPEED_POT, CMD_PAUSE,
            CMD_PINS, CMD_KEY, CMD_HSCW, CMD_FARNSWORTH, CMD_MODE:
                return 1;
            {3'b000, CMD_PTT}:
                return 2;
            default:
                return 0;
        endcase
    endfunction

    function automatic logic [3:0] arg_event(input logic [4:0] c);
        case ({3'b000, c})
            CMD_SPEED:    return EV_SPEED;
            CMD_SIDETONE: return EV_SIDETONE;
            CMD_WEIGHT:   return EV_WEIGHT;
            CMD_PINS:     return EV_PINS;
            CMD_MODE:     return EV_MODE;
            CMD_KEY:      return EV_KEY;
            CMD_PAUSE:    return EV_PAUSE;
            default:      return EV_NONE;
        endcase
    endfunction

    // Advances the parse state by one host byte and returns the result it produces.
    function automatic result_t decode_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (phase)
            PH_IDLE:
            begin
                if (b <= CMD_MAX)
                begin
                    if (b[4:0] == CMD_ADMIN)
                    begin
                        phase = PH_ADMIN;
                    end
                    else if (arg_bytes(b[4:0]) != 0)
                    begin
                        cmd_held = b[4:0];
                        phase = PH_PARAM1;
                    end
                    else if (link_open && b[4:0] == CMD_CLEAR)
                    begin
                        r.event_code = EV_CLEAR;
                    end
                end
                else if (b <= TEXT_MAX && link_open)
                begin
                    r.event_code = EV_TEXT;
                    r.arg_first = b;
                end
            end
            PH_ADMIN:
            begin
                phase = PH_IDLE;
                if (b == SUB_OPEN)
                begin
                    link_open = 1'b1;
                    r.event_code = EV_OPEN;
                    r.reply_valid = 1'b1;
                    r.reply_byte = version_reg;
                end
                else if (b == SUB_CLOSE)
                begin
                    link_open = 1'b0;
                    r.event_code = EV_CLOSE;
                end
                else if (b == SUB_RESET)
                begin
                    link_open = 1'b0;
                end
                else if (b == SUB_ECHO)
                begin
                    // The echo marker is kept in the held parameter, with the admin command as the pending command.
                    cmd_held = CMD_ADMIN;
                    first_param = SUB_ECHO;
                    phase = PH_PARAM1;
                end
            end
            PH_PARAM1:
            begin
                phase = PH_IDLE;
                if (cmd_held == CMD_ADMIN && first_param == SUB_ECHO)
                begin
                    r.reply_valid = 1'b1;
                    r.reply_byte = b;
                end
                else if (arg_bytes(cmd_held) == 2)
                begin
                    if (link_open)
                        first_param = b;
                    phase = PH_PARAM2;
                end
                else if (link_open)
                begin
                    r.event_code = arg_event(cmd_held);
                    if (r.event_code == EV_KEY || r.event_code == EV_PAUSE)
                        r.arg_first = (b != 8'h00) ? 8'h01 : 8'h00;
                    else if (r.event_code != EV_NONE)
                        r.arg_first = b;
                end
            end
            default:
            begin
                phase = PH_IDLE;
                if (link_open && cmd_held == CMD_PTT)
                begin
                    r.event_code = EV_PTT;
                    r.arg_first = first_param;
                    r.arg_second = b;
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("t=%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            phase = PH_IDLE;
            cmd_held = '0;
            first_param = '0;
            link_open = 1'b0;
            version_reg = VERSION_RESET;
            expected_q.delete();
            outstanding = 0;
            mismatches = 0;
            replies_seen = 0;
            events_seen = '0;
        end
        else
        begin
            // Results leave before new bytes are predicted, so the queue front stays the oldest.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[28:0];
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("t=%0t result %0h with no byte outstanding", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("event_code", 32'(want.event_code), 32'(got.event_code));
                    compare_field("arg_first", 32'(want.arg_first), 32'(got.arg_first));
                    compare_field("arg_second", 32'(want.arg_second), 32'(got.arg_second));
                    compare_field("reply_valid", 32'(want.reply_valid), 32'(got.reply_valid));
                    compare_field("reply_byte", 32'(want.reply_byte), 32'(got.reply_byte));
                    compare_field("padding", 32'd0, 32'(m_tdata[31:29]));
                end
            end
            if (cfg_valid && cfg_ready)
                version_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                want = decode_byte(s_tdata);
                expected_q.push_back(want);
                events_seen[want.event_code] = 1'b1;
                if (want.reply_valid)
                    replies_seen++;
            end
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the keyer host command parser: clock, reset, host byte stimulus and verdict.
module tb;

    import ckp_pkg::*;
    import ckp_tb_pkg::*;

    localparam int RANDOM_ITEMS = 920;
    localparam int PHASES       = 6;
    localparam int LONG_HOLD    = 80;
    localparam int LIMIT_CYCLES = 200000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        cfg_ready;

    int          mismatches;
    int          outstanding;
    int          replies_seen;
    logic [15:0] events_seen;

    int cycle_count    = 0;
    int sent_total     = 0;
    int ignored_total  = 0;
    int version_writes = 0;
    int stim_phase     = -1;
    bit gaps_on        = 1'b1;

    always #2 clk = ~clk;

    cw_keyer_host_command_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ckp_checker result_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .events_seen  (events_seen),
        .replies_seen (replies_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold while the sender keeps going.
    initial
    begin : receiver
        bit held_once;
        held_once = 1'b0;
        @(posedge clk);
        forever
        begin
            if (stim_phase == 1 && !held_once)
            begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_total++;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Waits until every result is back; stale reads of the count only make the wait longer.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    task automatic write_version(input logic [7:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        version_writes++;
    endtask

    function automatic logic [7:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed host sentence with random content, or occasionally raw noise.
    task automatic send_sentence();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            send_byte(8'(CMD_ADMIN));
            send_byte(SUB_OPEN);
        end
        else if (pick < 15)
        begin
            send_byte(8'(CMD_ADMIN));
            send_byte(SUB_CLOSE);
        end
        else if (pick < 17)
        begin
            send_byte(8'(CMD_ADMIN));
            send_byte(SUB_RESET);
        end
        else if (pick < 22)
        begin
            send_byte(8'(CMD_ADMIN));
            send_byte(SUB_ECHO);
            send_byte(pick_arg());
        end
        else if (pick < 25)
        begin
            send_byte(8'(CMD_ADMIN));
            if ($urandom_range(0, 3) == 0)
                send_byte(8'h00);
            else
                send_byte(8'($urandom_range(SUB_ECHO + 1, 255)));
        end
        else if (pick < 50)
        begin
            send_byte(one_arg_command($urandom_range(0, ONE_ARG_COUNT - 1)));
            send_byte(pick_arg());
        end
        else if (pick < 59)
        begin
            send_byte(8'(CMD_PTT));
            send_byte(pick_arg());
            send_byte(pick_arg());
        end
        else if (pick < 66)
        begin
            case ($urandom_range(0, 3))
                0:       send_byte(8'(CMD_CLEAR));
                1:       send_byte(CMD_GET_POT);
                2:       send_byte(CMD_BACKSPACE);
                default: send_byte(8'($urandom_range(CMD_NOARG_LO, CMD_NOARG_HI)));
            endcase
        end
        else if (pick < 84)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(CMD_MAX + 1, TEXT_MAX)));
        end
        else if (pick < 88)
        begin
            send_byte(8'($urandom_range(TEXT_MAX + 1, 255)));
            ignored_total++;
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int base;
        int goal;
        logic [7:0] ver;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: open with the reset version, then every event while the session is open.
        send_byte(8'(CMD_ADMIN));
        send_byte(SUB_OPEN);
        send_byte(TEXT_MAX);
        send_byte(8'(CMD_CLEAR));
        send_byte(CMD_SPEED);
        send_byte(8'hFF);
        send_byte(CMD_SIDETONE);
        send_byte(8'h00);
        send_byte(CMD_WEIGHT);
        send_byte(8'h55);
        send_byte(CMD_PINS);
        send_byte(8'hAA);
        send_byte(CMD_MODE);
        send_byte(8'h13);
        send_byte(CMD_KEY);
        send_byte(8'h00);
        send_byte(CMD_PAUSE);
        send_byte(8'h80);
        send_byte(8'(CMD_PTT));
        send_byte(8'h80);
        send_byte(8'h7F);
        // An unimplemented command still eats its parameter.
        send_byte(CMD_FARNSWORTH);
        send_byte(8'h33);
        send_byte(CMD_NOARG_HI);
        send_byte(8'hFF);
        ignored_total++;
        send_byte(8'(CMD_ADMIN));
        send_byte(SUB_ECHO);
        send_byte(8'h00);
        send_byte(8'(CMD_ADMIN));
        send_byte(SUB_CLOSE);
        // Text with the session closed gives no event.
        send_byte(8'(CMD_MAX + 1));
        send_byte(8'(CMD_ADMIN));
        send_byte(SUB_RESET);
        send_byte(8'(CMD_ADMIN));
        send_byte(8'hA5);

        base = sent_total - ignored_total;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       ver = 8'h00;
                1:       ver = 8'hFF;
                3:       ver = 8'h80;
                default: ver = 8'($urandom_range(0, 255));
            endcase
            write_version(ver);
            stim_phase = p;
            gaps_on = (p != 2 && p != PHASES - 1);
            goal = base + ((p + 1) * RANDOM_ITEMS) / PHASES;
            while (sent_total - ignored_total < goal)
                send_sentence();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d host bytes (%0d ignored high bytes) under %0d version byte writes.",
                 sent_total, ignored_total, version_writes);
        $display("Event codes seen, one bit per code: %b; %0d reply bytes expected.",
                 events_seen[12:0], replies_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- cw_keyer_host_command_parser.f -----
rtl/ckp_pkg.sv
rtl/ckp_decode.sv
rtl/cw_keyer_host_command_parser.sv
rtl/ckp_checker.sv
sim/ckp_checker.sv
sim/tb.sv
